/* src/mpl2n_pkg.sv */
// Shared types and constants for the masked pooling / L2 normalize block.
// Used by mpl2n_div and masked_pooling_l2_normalize; depends on nothing.
package mpl2n_pkg;

	// item field widths
	localparam int VALUE_BITS = 24;
	localparam int IDX_W      = 10;
	localparam int FRAC_BITS  = 16;

	// tokens at this position and beyond are ignored
	localparam int SEQ_MAX = 512;

	// internal widths
	localparam int ACC_W  = 34;
	localparam int CNT_W  = 10;
	localparam int NORM_W = 32;
	localparam int DVD_W  = 41;
	localparam int SQ_W   = 64;
	localparam int PROD_W = 2 * VALUE_BITS;

	// configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOLING_MODE = 2'd0,
		REG_NORMALIZE    = 2'd1,
		REG_DIM          = 2'd2
	} cfg_reg_t;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// pooling modes
	localparam logic MODE_CLS  = 1'b0;
	localparam logic MODE_MEAN = 1'b1;

	// reset values of the registers
	localparam logic             RST_MODE = MODE_CLS;
	localparam logic             RST_NORM = 1'b1;
	localparam logic [CFG_W-1:0] RST_DIM  = 11'd1024;

	// saturation limits
	localparam logic signed [ACC_W-1:0] VAL_MAX =
		{{(ACC_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] VAL_MIN =
		{{(ACC_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'd1 << (VALUE_BITS-1));
	localparam logic [DVD_W-1:0] POS_LIM = NEG_LIM - DVD_W'(1);

	// square root iterations, two bits of radicand each
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int SQRT_IT_W  = $clog2(SQRT_STEPS);

endpackage

/* src/mpl2n_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mpl2n_pkg for the dividend and divisor widths.
module mpl2n_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [mpl2n_pkg::DVD_W-1:0]    dividend,
	input  logic [mpl2n_pkg::NORM_W-1:0]   divisor,
	output logic                           done,
	output logic [mpl2n_pkg::DVD_W-1:0]    quotient
);
	import mpl2n_pkg::*;

	localparam int DC_W = $clog2(DVD_W);
	localparam logic [DC_W-1:0] LAST_STEP = DC_W'(DVD_W - 1);

	logic              run_q;
	logic              done_q;
	logic [DC_W-1:0]   step_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [NORM_W-1:0] rem_q;
	logic [NORM_W-1:0] dsr_q;
	logic [NORM_W:0]   rem_sh;
	logic              fits;

	// one trial subtraction per cycle
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + DC_W'(1);
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, the dividend register fills with quotient bits
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? NORM_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[NORM_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* src/masked_pooling_l2_normalize.sv */
// Masked mean / first-token pooling with optional L2 normalization.
// Depends on mpl2n_pkg and mpl2n_div.
//
// Items enter on start while busy is low. A load item (func 0) adds one
// hidden element into the accumulator memory in mean mode if masked in,
// or stores it for the first token in first-token mode; loads run one
// per cycle while busy is low, a read-modify-write with forwarding
// between back-to-back elements. A load with seq_last raises busy for
// finalization: a setup state, then per effective-dimension element:
//   first-token mode: read and write; when normalizing, square and sum
//   mean mode:  read, divide by the token count on the shared divider,
//               write; when normalizing, square and sum as well
//   then, when normalizing: a digit-by-digit square root and, unless
//               the norm is zero, divides of each element by the norm
//   mean mode with no masked-in token: all DIM_MAX entries zeroed.
// A read item (func 1) after finalization gives one result in the next
// cycle, on done for exactly one cycle; reads run one per cycle. Reads
// before finalization give no result. The receiver cannot stall.
// The first load after a finished sequence triggers a clearing sweep of
// the memory (busy high), then is processed. Reset also starts the sweep.
// Configuration writes land on cfg_we at once and are taken at any time.
module masked_pooling_l2_normalize #(
	parameter int DIM_MAX = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 func,
	input  logic signed [mpl2n_pkg::VALUE_BITS-1:0] value,
	input  logic                                 token_mask,
	input  logic [mpl2n_pkg::IDX_W-1:0]          element_index,
	input  logic                                 seq_last,
	output logic                                 done,
	output logic signed [mpl2n_pkg::VALUE_BITS-1:0] pooled_value,
	output logic [mpl2n_pkg::IDX_W-1:0]          out_index,
	output logic                                 last,
	output logic                                 no_tokens,
	input  logic                                 cfg_we,
	input  logic [mpl2n_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpl2n_pkg::CFG_W-1:0]          cfg_wdata
);
	import mpl2n_pkg::*;

	localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
	localparam int CW = ($clog2(DIM_MAX + 1) > CFG_W) ? $clog2(DIM_MAX + 1) : CFG_W;
	localparam logic [CW-1:0] DIM_MAX_C  = CW'(DIM_MAX);
	localparam logic [CW-1:0] SWEEP_LAST = CW'(DIM_MAX - 1);
	localparam logic [CNT_W-1:0] CNT_TOP = '1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_REPLAY, S_FSTART, S_ZERO,
		S_P1_RD, S_P1_WAIT, S_P1_DIV, S_P1_SQ, S_P1_ACC,
		S_SQRT, S_P3_RD, S_P3_WAIT, S_P3_DIV
	} state_t;

	state_t state_q;

	// configuration
	logic             mode_q;
	logic             norm_en_q;
	logic [CFG_W-1:0] dim_cfg_q;

	// sequence state
	logic              ready_q;
	logic              empty_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  pos_q;
	logic [NORM_W-1:0] scale_q;
	logic              fin_mode_q;
	logic              fin_norm_q;
	logic [CW-1:0]     fin_last_q;
	logic [CW-1:0]     d_q;
	logic [SQRT_IT_W-1:0] it_q;

	// held load item during the clearing sweep
	logic                         pend_v_q;
	logic [IDX_W-1:0]             pend_idx_q;
	logic signed [VALUE_BITS-1:0] pend_val_q;
	logic                         pend_mask_q;
	logic                         pend_last_q;
	logic                         pend_mode_q;

	// load pipeline and forwarding
	logic                         ld_v_s1;
	logic                         ld_set_s1;
	logic [AW-1:0]                ld_addr_s1;
	logic signed [VALUE_BITS-1:0] ld_val_s1;
	logic                         wr_v_q;
	logic [AW-1:0]                wr_a_q;
	logic signed [ACC_W-1:0]      wr_d_q;

	// read pipeline
	logic             rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_rng_s1;
	logic             rd_last_s1;
	logic             rd_empty_s1;

	// finalization datapath
	logic                    neg_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [PROD_W-1:0]       prod_q;
	logic [SQ_W-1:0]         sq_q;
	logic [SQ_W-1:0]         sx_q;
	logic [SQ_W-1:0]         sr_q;
	logic [SQ_W-1:0]         sb_q;

	// memory
	logic signed [ACC_W-1:0] mem [DIM_MAX];
	logic signed [ACC_W-1:0] rdata_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_wa;
	logic signed [ACC_W-1:0] mem_wd;
	logic [AW-1:0]           mem_ra;

	// combinational
	logic [CW-1:0]                dim_eff;
	logic [CW-1:0]                dim_m1;
	logic                         iss_go;
	logic [IDX_W-1:0]             iss_idx;
	logic signed [VALUE_BITS-1:0] iss_val;
	logic                         iss_mask;
	logic                         iss_last;
	logic                         iss_mode;
	logic                         iss_rng;
	logic                         pos_ok;
	logic                         do_set;
	logic                         do_add;
	logic                         bnd;
	logic                         rd_go;
	logic                         new_seq;
	logic signed [ACC_W-1:0]      ld_base;
	logic signed [ACC_W:0]        ld_sum;
	logic signed [ACC_W-1:0]      ld_new;
	logic [ACC_W-1:0]             rd_mag;
	logic                         div_go;
	logic [DVD_W-1:0]             div_dvd;
	logic [NORM_W-1:0]            div_dsr;
	logic                         div_done;
	logic [DVD_W-1:0]             div_quot;
	logic signed [ACC_W-1:0]      wb_val;
	logic                         wb_we;
	logic [ACC_W-1:0]             wb_mag;
	logic                         d_last;
	logic [SQ_W:0]                sq_sum;
	logic [SQ_W-1:0]              sq_nxt;
	logic [SQ_W-1:0]              s_rb;
	logic                         s_ge;
	logic [SQ_W-1:0]              sx_n;
	logic [SQ_W-1:0]              sr_n;

	function automatic logic signed [ACC_W-1:0] sat_to_val(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > VAL_MAX)
			r = VAL_MAX;
		else if (v < VAL_MIN)
			r = VAL_MIN;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [ACC_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] r;
		r = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		return r;
	endfunction

	// quotient magnitude and sign back to a saturated element
	function automatic logic signed [ACC_W-1:0] q_to_val(input logic [DVD_W-1:0] q,
		input logic neg);
		logic signed [ACC_W-1:0] r;
		if (!neg)
			r = (q > POS_LIM) ? VAL_MAX : signed'(ACC_W'(q));
		else
			r = (q > NEG_LIM) ? VAL_MIN : -signed'(ACC_W'(q));
		return r;
	endfunction

	// effective dimension
	always_comb begin
		if (dim_cfg_q == '0)
			dim_eff = CW'(1);
		else if (CW'(dim_cfg_q) > DIM_MAX_C)
			dim_eff = DIM_MAX_C;
		else
			dim_eff = CW'(dim_cfg_q);
		dim_m1 = dim_eff - CW'(1);
	end

	// load issue: a fresh load, or the one held over the clearing sweep
	always_comb begin
		new_seq = (state_q == S_IDLE) && start && (func == FUNC_LOAD) && ready_q;
		rd_go   = (state_q == S_IDLE) && start && (func == FUNC_READ) && ready_q;
		if (state_q == S_REPLAY) begin
			iss_go   = 1'b1;
			iss_idx  = pend_idx_q;
			iss_val  = pend_val_q;
			iss_mask = pend_mask_q;
			iss_last = pend_last_q;
			iss_mode = pend_mode_q;
		end else begin
			iss_go   = (state_q == S_IDLE) && start && (func == FUNC_LOAD) && !ready_q;
			iss_idx  = element_index;
			iss_val  = value;
			iss_mask = token_mask;
			iss_last = seq_last;
			iss_mode = mode_q;
		end
		iss_rng = CW'(iss_idx) < dim_eff;
		pos_ok  = 32'(pos_q) < SEQ_MAX;
		do_set  = pos_ok && iss_rng && (iss_mode == MODE_CLS) && (pos_q == '0);
		do_add  = pos_ok && iss_rng && (iss_mode == MODE_MEAN) && iss_mask;
		bnd     = (CW'(iss_idx) == dim_m1) || iss_last;
	end

	// load update with forwarding of the previous cycle's write
	always_comb begin
		ld_base = (wr_v_q && (wr_a_q == ld_addr_s1)) ? wr_d_q : rdata_q;
		ld_sum  = {ld_base[ACC_W-1], ld_base} + (ACC_W+1)'(ld_val_s1);
		if (ld_set_s1)
			ld_new = ACC_W'(ld_val_s1);
		else if (ld_sum[ACC_W] != ld_sum[ACC_W-1])
			ld_new = ld_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		else
			ld_new = ld_sum[ACC_W-1:0];
	end

	// finalization arithmetic
	always_comb begin
		rd_mag  = mag_of(rdata_q);
		div_go  = ((state_q == S_P1_WAIT) && (fin_mode_q == MODE_MEAN)) ||
			(state_q == S_P3_WAIT);
		if (state_q == S_P3_WAIT) begin
			div_dvd = (DVD_W'(rd_mag[VALUE_BITS-1:0]) << FRAC_BITS) + DVD_W'(scale_q >> 1);
			div_dsr = scale_q;
		end else begin
			div_dvd = DVD_W'(rd_mag) + DVD_W'(cnt_q >> 1);
			div_dsr = NORM_W'(cnt_q);
		end
		wb_val = (state_q == S_P1_WAIT) ? sat_to_val(rdata_q) : q_to_val(div_quot, neg_q);
		wb_we  = ((state_q == S_P1_WAIT) && (fin_mode_q == MODE_CLS)) ||
			(((state_q == S_P1_DIV) || (state_q == S_P3_DIV)) && div_done);
		wb_mag = mag_of(wb_val);
		d_last = d_q == fin_last_q;
		sq_sum = {1'b0, sq_q} + (SQ_W+1)'(prod_q);
		sq_nxt = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
		s_rb   = sr_q + sb_q;
		s_ge   = sx_q >= s_rb;
		sx_n   = s_ge ? sx_q - s_rb : sx_q;
		sr_n   = s_ge ? (sr_q >> 1) + sb_q : sr_q >> 1;
	end

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = d_q[AW-1:0];
		mem_wd = '0;
		if (ld_v_s1) begin
			mem_we = 1'b1;
			mem_wa = ld_addr_s1;
			mem_wd = ld_new;
		end else if ((state_q == S_CLEAR) || (state_q == S_ZERO)) begin
			mem_we = 1'b1;
		end else if (wb_we) begin
			mem_we = 1'b1;
			mem_wd = wb_val;
		end
		if ((state_q == S_P1_RD) || (state_q == S_P3_RD))
			mem_ra = d_q[AW-1:0];
		else
			mem_ra = CW'(iss_idx) < CW'(DIM_MAX) ? AW'(CW'(iss_idx)) : '0;
	end

	// accumulator memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	mpl2n_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quot)
	);

	// control state machine and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			mode_q     <= RST_MODE;
			norm_en_q  <= RST_NORM;
			dim_cfg_q  <= RST_DIM;
			ready_q    <= 1'b0;
			empty_q    <= 1'b0;
			cnt_q      <= '0;
			pos_q      <= '0;
			scale_q    <= '0;
			fin_mode_q <= MODE_CLS;
			fin_norm_q <= 1'b0;
			fin_last_q <= '0;
			d_q        <= '0;
			it_q       <= '0;
			pend_v_q   <= 1'b0;
			ld_v_s1    <= 1'b0;
			wr_v_q     <= 1'b0;
			rd_v_s1    <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_POOLING_MODE: mode_q    <= cfg_wdata[0];
					REG_NORMALIZE:    norm_en_q <= cfg_wdata[0];
					REG_DIM:          dim_cfg_q <= cfg_wdata;
					default: ;
				endcase
			end

			ld_v_s1 <= iss_go && (do_set || do_add);
			wr_v_q  <= ld_v_s1;
			rd_v_s1 <= rd_go;

			case (state_q)
				S_CLEAR: begin
					if (d_q == SWEEP_LAST) begin
						d_q     <= '0;
						state_q <= pend_v_q ? S_REPLAY : S_IDLE;
					end else begin
						d_q <= d_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (new_seq) begin
						pend_v_q <= 1'b1;
						ready_q  <= 1'b0;
						empty_q  <= 1'b0;
						cnt_q    <= '0;
						pos_q    <= '0;
						scale_q  <= '0;
						d_q      <= '0;
						state_q  <= S_CLEAR;
					end else if (iss_go && iss_last) begin
						state_q <= S_FSTART;
					end
				end
				S_REPLAY: begin
					pend_v_q <= 1'b0;
					state_q  <= pend_last_q ? S_FSTART : S_IDLE;
				end
				S_FSTART: begin
					d_q <= '0;
					if ((fin_mode_q == MODE_MEAN) && (cnt_q == '0)) begin
						empty_q <= 1'b1;
						state_q <= S_ZERO;
					end else begin
						state_q <= S_P1_RD;
					end
				end
				S_ZERO: begin
					if (d_q == SWEEP_LAST) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						d_q <= d_q + CW'(1);
					end
				end
				S_P1_RD: state_q <= S_P1_WAIT;
				S_P1_WAIT, S_P1_DIV: begin
					if (state_q == S_P1_WAIT && fin_mode_q == MODE_MEAN) begin
						state_q <= S_P1_DIV;
					end else if (wb_we) begin
						if (fin_norm_q) begin
							state_q <= S_P1_SQ;
						end else if (d_last) begin
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							d_q     <= d_q + CW'(1);
							state_q <= S_P1_RD;
						end
					end
				end
				S_P1_SQ: state_q <= S_P1_ACC;
				S_P1_ACC: begin
					if (d_last) begin
						it_q    <= '0;
						state_q <= S_SQRT;
					end else begin
						d_q     <= d_q + CW'(1);
						state_q <= S_P1_RD;
					end
				end
				S_SQRT: begin
					it_q <= it_q + SQRT_IT_W'(1);
					if (it_q == '1) begin
						scale_q <= sr_n[NORM_W-1:0];
						d_q     <= '0;
						if (sr_n == '0) begin
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_P3_RD;
						end
					end
				end
				S_P3_RD:   state_q <= S_P3_WAIT;
				S_P3_WAIT: state_q <= S_P3_DIV;
				S_P3_DIV: begin
					if (div_done) begin
						if (d_last) begin
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							d_q     <= d_q + CW'(1);
							state_q <= S_P3_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// token bookkeeping on every issued load
			if (iss_go) begin
				if (bnd) begin
					if (pos_ok && iss_mask && (cnt_q != CNT_TOP))
						cnt_q <= cnt_q + CNT_W'(1);
					if (pos_q != CNT_TOP)
						pos_q <= pos_q + CNT_W'(1);
				end
				if (iss_last) begin
					fin_mode_q <= iss_mode;
					fin_norm_q <= norm_en_q;
					fin_last_q <= dim_m1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ld_set_s1  <= do_set;
		ld_addr_s1 <= mem_ra;
		ld_val_s1  <= iss_val;
		wr_a_q     <= ld_addr_s1;
		wr_d_q     <= ld_new;
		rd_idx_s1   <= element_index;
		rd_rng_s1   <= CW'(element_index) < dim_eff;
		rd_last_s1  <= CW'(element_index) == dim_m1;
		rd_empty_s1 <= empty_q;
		if (new_seq) begin
			pend_idx_q  <= element_index;
			pend_val_q  <= value;
			pend_mask_q <= token_mask;
			pend_last_q <= seq_last;
			pend_mode_q <= mode_q;
		end
		if (div_go)
			neg_q <= rdata_q[ACC_W-1];
		if (wb_we)
			mag_q <= wb_mag[VALUE_BITS-1:0];
		prod_q <= PROD_W'(mag_q * mag_q);
		if (state_q == S_FSTART)
			sq_q <= '0;
		else if (state_q == S_P1_ACC)
			sq_q <= sq_nxt;
		// square root, digit by digit
		if (state_q == S_P1_ACC) begin
			sx_q <= sq_nxt;
			sr_q <= '0;
			sb_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (state_q == S_SQRT) begin
			sx_q <= sx_n;
			sr_q <= sr_n;
			sb_q <= sb_q >> 2;
		end
	end

	// result ports
	assign busy         = state_q != S_IDLE;
	assign done         = rd_v_s1;
	assign pooled_value = rd_rng_s1 ? rdata_q[VALUE_BITS-1:0] : '0;
	assign out_index    = rd_idx_s1;
	assign last         = rd_last_s1;
	assign no_tokens    = rd_empty_s1;

endmodule

/* tb/sv/tb_masked_pooling_l2_normalize.sv */
// Self-checking testbench for masked_pooling_l2_normalize: streams hidden
// vectors and reads, predicts every pooled element, checks each result.
// Depends on mpl2n_pkg and the block's RTL only.
module tb_masked_pooling_l2_normalize;
	timeunit 1ns;
	timeprecision 1ps;
	import mpl2n_pkg::*;

	localparam int DMAX = 1024;
	localparam longint V_HI = 64'sd8388607;
	localparam longint V_LO = -64'sd8388608;
	localparam longint A_HI = 64'sd17179869183;
	localparam longint A_LO = -64'sd17179869184;

	typedef struct packed {
		logic                  func;
		logic [VALUE_BITS-1:0] value;
		logic                  mask;
		logic [IDX_W-1:0]      idx;
		logic                  slast;
	} op_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [IDX_W-1:0]      idx;
		logic                  last;
		logic                  empty;
	} pooled_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic signed [VALUE_BITS-1:0] pooled_value;
	logic [IDX_W-1:0] out_index;
	logic last;
	logic no_tokens;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	op_t cur = '0;

	masked_pooling_l2_normalize u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(cur.func), .value(cur.value), .token_mask(cur.mask),
		.element_index(cur.idx), .seq_last(cur.slast),
		.done(done), .pooled_value(pooled_value), .out_index(out_index),
		.last(last), .no_tokens(no_tokens),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// pooling state mirrored in the testbench
	longint pool_acc [DMAX];
	int     tok_cnt, tok_pos;
	bit     pool_ready, pool_empty;
	logic   cur_mode, cur_norm;
	int     cur_dim;

	op_t     pend_items [$];
	pooled_t pooled_q [$];
	int      errors = 0, n_items = 0, n_results = 0, n_seqs = 0;

	function automatic int eff_dim();
		if (cur_dim == 0) return 1;
		if (cur_dim > DMAX) return DMAX;
		return cur_dim;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// nearest, ties away from zero
	function automatic longint div_near(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void clear_pool();
		foreach (pool_acc[i]) pool_acc[i] = 0;
		tok_cnt = 0;
		tok_pos = 0;
		pool_ready = 0;
		pool_empty = 0;
	endfunction

	// mean, saturate, then optional division by the L2 norm
	function automatic void finish_pool();
		int dim;
		longint unsigned sq;
		longint unsigned nrm;
		dim = eff_dim();
		if (cur_mode == MODE_MEAN) begin
			if (tok_cnt == 0) begin
				foreach (pool_acc[i]) pool_acc[i] = 0;
				pool_empty = 1;
			end else begin
				for (int d = 0; d < dim; d++) pool_acc[d] = div_near(pool_acc[d], tok_cnt);
			end
		end
		for (int d = 0; d < dim; d++) pool_acc[d] = clamp(pool_acc[d], V_LO, V_HI);
		if (cur_norm) begin
			sq = 0;
			for (int d = 0; d < dim; d++) sq += pool_acc[d] * pool_acc[d];
			nrm = int_sqrt(sq);
			if (nrm != 0)
				for (int d = 0; d < dim; d++)
					pool_acc[d] = clamp(div_near(pool_acc[d] * 65536, nrm), V_LO, V_HI);
		end
		pool_ready = 1;
	endfunction

	// predict one accepted item
	function automatic void pool_item(op_t it);
		int dim;
		longint v;
		pooled_t r;
		dim = eff_dim();
		if (it.func == FUNC_READ) begin
			if (!pool_ready) return;
			r.value = (it.idx < dim) ? pool_acc[it.idx][VALUE_BITS-1:0] : '0;
			r.idx = it.idx;
			r.last = (it.idx == dim - 1);
			r.empty = pool_empty;
			pooled_q.push_back(r);
			return;
		end
		if (pool_ready) clear_pool();
		v = longint'($signed(it.value));
		if (tok_pos < SEQ_MAX && it.idx < dim) begin
			if (cur_mode == MODE_CLS) begin
				if (tok_pos == 0) pool_acc[it.idx] = v;
			end else if (it.mask) begin
				pool_acc[it.idx] = clamp(pool_acc[it.idx] + v, A_LO, A_HI);
			end
		end
		if (it.idx == dim - 1 || it.slast) begin
			if (tok_pos < SEQ_MAX && it.mask && tok_cnt < 1023) tok_cnt++;
			if (tok_pos < 1023) tok_pos++;
		end
		if (it.slast) finish_pool();
	endfunction

	// driver: bursts of items with random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) pool_item(cur);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pend_items.size() > 0) begin
					cur <= pend_items.pop_front();
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		pooled_t e;
		if (arst_n && done) begin
			n_results++;
			if (pooled_q.size() == 0) begin
				errors++;
				$display("%t: unexpected result idx %0d value %h", $realtime, out_index,
					pooled_value);
			end else begin
				e = pooled_q.pop_front();
				if (e.value !== pooled_value || e.idx !== out_index || e.last !== last
						|| e.empty !== no_tokens) begin
					errors++;
					$display("%t: mismatch exp val %h idx %0d last %b empty %b", $realtime,
						e.value, e.idx, e.last, e.empty);
					$display("%t:          got val %h idx %0d last %b empty %b", $realtime,
						pooled_value, out_index, last, no_tokens);
				end
			end
		end
	end

	task automatic push_op(logic f, logic [VALUE_BITS-1:0] v, logic m, int i, logic s);
		op_t it;
		it.func = f;
		it.value = v;
		it.mask = m;
		it.idx = i[IDX_W-1:0];
		it.slast = s;
		pend_items.push_back(it);
		n_items++;
	endtask

	function automatic logic [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	// whole tokens at the current dimension, then reads
	task automatic push_seq(int ntok, int mask_sel, int nread);
		int dim;
		logic m;
		dim = eff_dim();
		for (int t = 0; t < ntok; t++) begin
			m = (mask_sel == 2) ? 1'($urandom_range(0, 1)) : mask_sel[0];
			for (int d = 0; d < dim; d++)
				push_op(FUNC_LOAD, rand_value(), m, d, t == ntok - 1 && d == dim - 1);
		end
		for (int r = 0; r < nread; r++)
			push_op(FUNC_READ, VALUE_BITS'($urandom()), 1'($urandom_range(0, 1)),
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) :
				$urandom_range(0, dim + 1), 1'($urandom_range(0, 1)));
		n_seqs++;
	endtask

	// broken sequence: random indices, random reads, seq_last on the last item
	task automatic push_noise(int n);
		int dim;
		dim = eff_dim();
		for (int k = 0; k < n; k++)
			push_op($urandom_range(0, 3) == 0, rand_value(), 1'($urandom_range(0, 1)),
				($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) :
				$urandom_range(0, dim + 1), k == n - 1);
		for (int r = 0; r < 3; r++) push_op(FUNC_READ, '0, 1'b0, $urandom_range(0, dim), 1'b0);
	endtask

	// wait until everything sent has been taken and checked
	task automatic settle();
		do @(negedge clk);
		while (pend_items.size() != 0 || start || busy || pooled_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v[CFG_W-1:0];
		case (r)
			REG_POOLING_MODE: cur_mode = v[0];
			REG_NORMALIZE: cur_norm = v[0];
			default: cur_dim = int'(v[CFG_W-1:0]);
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_cfg(logic m, logic n, int d);
		write_reg(REG_POOLING_MODE, int'(m));
		write_reg(REG_NORMALIZE, int'(n));
		write_reg(REG_DIM, d);
	endtask

	initial begin
		clear_pool();
		cur_mode = RST_MODE;
		cur_norm = RST_NORM;
		cur_dim = int'(RST_DIM);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// read before anything is pooled gives nothing
		push_op(FUNC_READ, '0, 1'b0, 0, 1'b0);
		settle();
		// first token kept, extremes, out-of-range reads
		set_cfg(MODE_CLS, 1'b1, 4);
		push_seq(2, 2, 6);
		settle();
		// zero vector with normalization on
		push_op(FUNC_LOAD, '0, 1'b1, 0, 1'b0);
		push_op(FUNC_LOAD, '0, 1'b1, 1, 1'b1);
		push_op(FUNC_READ, '0, 1'b0, 0, 1'b0);
		push_op(FUNC_READ, '0, 1'b0, 3, 1'b0);
		settle();
		// mean without normalization, then no masked-in token
		set_cfg(MODE_MEAN, 1'b0, 3);
		push_seq(3, 2, 3);
		push_seq(2, 0, 2);
		settle();
		// mode switch in the middle of a sequence
		push_op(FUNC_LOAD, 24'h7FFFFF, 1'b1, 0, 1'b0);
		push_op(FUNC_LOAD, 24'h800000, 1'b1, 2, 1'b0);
		settle();
		write_reg(REG_POOLING_MODE, int'(MODE_CLS));
		push_op(FUNC_LOAD, 24'h123456, 1'b0, 7, 1'b1);
		push_op(FUNC_READ, '0, 1'b0, 2, 1'b0);
		settle();
		// dimension 0 behaves as 1
		set_cfg(MODE_MEAN, 1'b1, 0);
		push_seq(3, 1, 2);
		settle();

		// random phases, small dimensions mostly
		while (n_items < 700) begin
			set_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8));
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 6) == 0) push_noise($urandom_range(1, 12));
				else push_seq($urandom_range(1, 6), $urandom_range(0, 9) < 2 ? 0 : 2,
					$urandom_range(1, eff_dim() + 3));
			end
			settle();
		end

		// past the token limit and the position ceiling
		set_cfg(MODE_MEAN, 1'b1, 1);
		push_seq(1030, 2, 3);
		settle();
		// largest register value, sparse loads
		set_cfg(MODE_CLS, 1'b1, 2047);
		push_op(FUNC_LOAD, rand_value(), 1'b1, 5, 1'b0);
		push_op(FUNC_LOAD, rand_value(), 1'b0, 1023, 1'b0);
		push_op(FUNC_LOAD, rand_value(), 1'b1, 3, 1'b1);
		push_op(FUNC_READ, '0, 1'b0, 1023, 1'b0);
		push_op(FUNC_READ, '0, 1'b0, 5, 1'b0);
		settle();
		write_reg(REG_POOLING_MODE, int'(MODE_MEAN));
		push_op(FUNC_LOAD, 24'h7FFFFF, 1'b1, 1023, 1'b1);
		push_op(FUNC_READ, '0, 1'b0, 1023, 1'b0);
		settle();
		repeat (20) @(posedge clk);

		$display("covered %0d items in %0d sequences, %0d pooled results checked",
			n_items, n_seqs, n_results);
		if (errors == 0) $display("tb_masked_pooling_l2_normalize OK");
		else $display("tb_masked_pooling_l2_normalize NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#40ms;
		$display("tb_masked_pooling_l2_normalize NOT OK");
		$finish;
	end

endmodule
